// ===== sv/lesf_pkg.sv =====
// Shared types and constants of the largest empty square finder.
// No dependencies; imported by every module of the block but lesf_ram.
package lesf_pkg;

    // configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_OBSTACLE = 2'd0;
    localparam t_cfg_idx CFG_ROWS     = 2'd1;
    localparam t_cfg_idx CFG_COLS     = 2'd2;

    localparam int CFG_DATA_W  = 11;
    localparam int CHAR_W      = 8;
    localparam int OUT_POS_W   = 10;
    localparam int OUT_SIDE_W  = 11;

    localparam logic [CHAR_W-1:0]     OBSTACLE_RST = 8'd111;
    localparam logic [CFG_DATA_W-1:0] COUNT_RST    = 11'd1;

    // control of the cell held in the compute stage
    typedef struct packed {
        logic vld;
        logic obst;
        logic grid_end;
    } t_cell_ctl;

endpackage

// ===== sv/largest_empty_square_finder.sv =====
// Largest empty square finder: takes one grid cell per transfer in raster order and,
// once the last cell has passed the compute stage, offers the top row, left column and
// side of the largest obstacle-free square (side 0 when no cell is free; ties keep
// the square whose corner comes first). Cells are taken at one per clock cycle with
// no bubbles between rows or grids, outside the hold-off below; that figure is set
// by the line store, which is read once at each transfer and written back from the
// compute stage, with a bypass for one-column grids. The only hold-off is on a
// grid's last cell, while the previous grid's result is still in the compute stage
// or waits at the output under i_stall; one-cell grids therefore cannot run back to back.
// Write configuration only while idle.
// Depends on lesf_pkg, lesf_ram, lesf_scan and lesf_dp.
module largest_empty_square_finder
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [CHAR_W-1:0]     i_cell_char,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [OUT_POS_W-1:0]  o_best_row,
    output logic [OUT_POS_W-1:0]  o_best_col,
    output logic [OUT_SIDE_W-1:0] o_best_side
);
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SW = $clog2(MAX_COLS + 1);

    t_cell_ctl     s1_ctl;
    logic [RW-1:0] s1_row;
    logic [CW-1:0] s1_col;
    logic          rd_en, wr_en;
    logic [CW-1:0] rd_addr, wr_addr;
    logic [SW-1:0] rd_data, wr_data;
    logic          out_blocked;

    // a result that leaves at this edge frees the output for the next grid
    assign out_blocked = o_valid && i_stall;

    lesf_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_cell_char (i_cell_char),
        .i_out_full  (out_blocked),
        .o_stall     (o_stall),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_ctl       (s1_ctl),
        .o_row       (s1_row),
        .o_col       (s1_col)
    );

    lesf_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_COLS)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lesf_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (s1_ctl),
        .i_row       (s1_row),
        .i_col       (s1_col),
        .i_rd_data   (rd_data),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .i_stall     (i_stall),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_valid     (o_valid),
        .o_best_row  (o_best_row),
        .o_best_col  (o_best_col),
        .o_best_side (o_best_side)
    );

    // a grid end must never land on a result that is still waiting
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_ctl.vld && s1_ctl.grid_end) |-> !o_valid)
        else $error("grid end reached while a result was still pending");

    // a result appears only after a grid-ending cell
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(s1_ctl.vld && s1_ctl.grid_end))
        else $error("result raised without a grid end");

    // the line store is written only for cells that were read on entry
    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> $past(rd_en))
        else $error("line store written without a preceding read");

endmodule

// ===== sv/lesf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; a new value written and read at the same edge returns the old one.
module lesf_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/lesf_scan.sv =====
// Front stage: configuration registers, raster position counters, input handshake
// and line-store read issue. Depends on lesf_pkg.
module lesf_scan
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  logic [CHAR_W-1:0]     i_cell_char,
    input  logic                  i_out_full,
    output logic                  o_stall,
    output logic                  o_rd_en,
    output logic [CW-1:0]         o_rd_addr,
    output t_cell_ctl             o_ctl,
    output logic [RW-1:0]         o_row,
    output logic [CW-1:0]         o_col
);
    localparam int CSW = $clog2(MAX_COLS + 1);
    localparam int RSW = $clog2(MAX_ROWS + 1);
    localparam int CCW = (CSW > CFG_DATA_W) ? CSW : CFG_DATA_W;
    localparam int RCW = (RSW > CFG_DATA_W) ? RSW : CFG_DATA_W;

    logic [CHAR_W-1:0]     r_obstacle;
    logic [CFG_DATA_W-1:0] r_rows_cfg;
    logic [CFG_DATA_W-1:0] r_cols_cfg;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         r_col;
    t_cell_ctl             r_ctl;
    logic [RW-1:0]         r_s1_row;
    logic [CW-1:0]         r_s1_col;

    logic [CCW-1:0] cols_cnt, cols_eff, col_next;
    logic [RCW-1:0] rows_cnt, rows_eff, row_next;
    logic           last_col, last_row, at_end, accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obstacle <= OBSTACLE_RST;
            r_rows_cfg <= COUNT_RST;
            r_cols_cfg <= COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OBSTACLE: r_obstacle <= i_cfg_data[CHAR_W-1:0];
                CFG_ROWS:     r_rows_cfg <= i_cfg_data;
                CFG_COLS:     r_cols_cfg <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // zero counts act as one, oversized counts as the maximum
    always_comb begin
        cols_cnt = (r_cols_cfg == '0) ? CCW'(1) : CCW'(r_cols_cfg);
        cols_eff = (cols_cnt > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : cols_cnt;
        rows_cnt = (r_rows_cfg == '0) ? RCW'(1) : RCW'(r_rows_cfg);
        rows_eff = (rows_cnt > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : rows_cnt;
        col_next = CCW'(r_col) + CCW'(1);
        row_next = RCW'(r_row) + RCW'(1);
        last_col = (col_next >= cols_eff);
        last_row = (row_next >= rows_eff);
        at_end   = last_col && last_row;
    end

    // hold off the grid-ending cell while an earlier result is still on its way out
    assign o_stall = at_end && (i_out_full || (r_ctl.vld && r_ctl.grid_end));
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_ctl.vld <= 1'b0;
        end else begin
            r_ctl.vld <= accept;
            if (accept) begin
                r_ctl.obst     <= (i_cell_char == r_obstacle);
                r_ctl.grid_end <= at_end;
                if (!last_col) begin
                    r_col <= CW'(col_next);
                end else begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : RW'(row_next);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_row <= r_row;
            r_s1_col <= r_col;
        end
    end

    assign o_rd_en   = accept;
    assign o_rd_addr = r_col;
    assign o_ctl     = r_ctl;
    assign o_row     = r_s1_row;
    assign o_col     = r_s1_col;

endmodule

// ===== sv/lesf_dp.sv =====
// Compute stage: square-side recurrence, line-store write-back with bypass,
// running best and result register. Depends on lesf_pkg.
module lesf_dp
    import lesf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int SW = $clog2(MAX_COLS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [RW-1:0]         i_row,
    input  logic [CW-1:0]         i_col,
    input  logic [SW-1:0]         i_rd_data,
    input  logic                  i_rd_en,
    input  logic [CW-1:0]         i_rd_addr,
    input  logic                  i_stall,
    output logic                  o_wr_en,
    output logic [CW-1:0]         o_wr_addr,
    output logic [SW-1:0]         o_wr_data,
    output logic                  o_valid,
    output logic [OUT_POS_W-1:0]  o_best_row,
    output logic [OUT_POS_W-1:0]  o_best_col,
    output logic [OUT_SIDE_W-1:0] o_best_side
);
    localparam int PW = (RW > SW) ? RW : SW;

    logic          r_fwd_hit;
    logic [SW-1:0] r_fwd_data;
    logic [SW-1:0] r_left;
    logic [SW-1:0] r_diag;
    logic [SW-1:0] r_best_side;
    logic [RW-1:0] r_best_row;
    logic [CW-1:0] r_best_col;
    logic          r_out_vld;
    logic [SW-1:0] r_out_side;
    logic [RW-1:0] r_out_row;
    logic [CW-1:0] r_out_col;

    logic [SW-1:0] up_raw, up, left, diag, m_ud, m_all, side_free, side;
    logic [PW-1:0] row_x, col_x, cap;
    logic          better;
    logic [SW-1:0] n_best_side;
    logic [RW-1:0] n_best_row;
    logic [CW-1:0] n_best_col;

    always_comb begin
        up_raw    = r_fwd_hit ? r_fwd_data : i_rd_data;
        up        = (i_row != '0) ? up_raw : '0;
        left      = (i_col != '0) ? r_left : '0;
        diag      = ((i_row != '0) && (i_col != '0)) ? r_diag : '0;
        m_ud      = (up < diag) ? up : diag;
        m_all     = (left < m_ud) ? left : m_ud;
        side_free = m_all + SW'(1);
        row_x     = PW'(i_row);
        col_x     = PW'(i_col);
        // cap at the largest square that fits above and to the left
        cap       = ((row_x < col_x) ? row_x : col_x) + PW'(1);
        if (i_ctl.obst) begin
            side = '0;
        end else begin
            side = (PW'(side_free) > cap) ? SW'(cap) : side_free;
        end

        better      = i_ctl.vld && (side > r_best_side);
        n_best_side = r_best_side;
        n_best_row  = r_best_row;
        n_best_col  = r_best_col;
        if (better) begin
            n_best_side = side;
            n_best_row  = RW'(row_x + PW'(1) - PW'(side));
            n_best_col  = CW'(col_x + PW'(1) - PW'(side));
        end
    end

    assign o_wr_en   = i_ctl.vld;
    assign o_wr_addr = i_col;
    assign o_wr_data = side;

    // bypass a write-back that lands on the entry read at the same edge
    always_ff @(posedge i_clk) begin
        r_fwd_hit  <= i_ctl.vld && i_rd_en && (i_rd_addr == i_col);
        r_fwd_data <= side;
        if (i_ctl.vld) begin
            r_left <= side;
            r_diag <= up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_side <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_ctl.vld && i_ctl.grid_end) begin
                r_best_side <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
                r_out_vld   <= 1'b1;
            end else begin
                r_best_side <= n_best_side;
                r_best_row  <= n_best_row;
                r_best_col  <= n_best_col;
                if (r_out_vld && !i_stall) begin
                    r_out_vld <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld && i_ctl.grid_end) begin
            r_out_side <= n_best_side;
            r_out_row  <= n_best_row;
            r_out_col  <= n_best_col;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_best_row  = OUT_POS_W'(r_out_row);
    assign o_best_col  = OUT_POS_W'(r_out_col);
    assign o_best_side = OUT_SIDE_W'(r_out_side);

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for largest_empty_square_finder: directed grids, count
// extremes, a long output hold-off and random grids, checked against a local predictor.
// Depends on lesf_pkg and the largest_empty_square_finder RTL.
module tb_top;
    import lesf_pkg::*;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int RANDOM_CELLS = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 5000;
    localparam int PRINT_LIMIT  = 50;

    // register index with no register behind it
    localparam t_cfg_idx CFG_UNUSED = 2'd3;

    localparam logic [CHAR_W-1:0] CH_FREE  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_BLOCK = 8'h23;

    typedef struct packed {
        logic [OUT_POS_W-1:0]  row;
        logic [OUT_POS_W-1:0]  col;
        logic [OUT_SIDE_W-1:0] side;
    } t_square;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_idx = CFG_OBSTACLE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [CHAR_W-1:0]     i_cell_char = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [OUT_POS_W-1:0]  o_best_row;
    logic [OUT_POS_W-1:0]  o_best_col;
    logic [OUT_SIDE_W-1:0] o_best_side;

    largest_empty_square_finder #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cell_char (i_cell_char),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_best_row  (o_best_row),
        .o_best_col  (o_best_col),
        .o_best_side (o_best_side)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state and its copy of the registers
    logic [CHAR_W-1:0]     obstacle_cfg = OBSTACLE_RST;
    logic [CFG_DATA_W-1:0] rows_cfg = COUNT_RST;
    logic [CFG_DATA_W-1:0] cols_cfg = COUNT_RST;
    logic [OUT_SIDE_W-1:0] line_sides [MAX_COLS];
    logic [OUT_SIDE_W-1:0] left_side_p = '0;
    logic [OUT_SIDE_W-1:0] diag_side_p = '0;
    logic [OUT_POS_W-1:0]  row_pos = '0;
    logic [OUT_POS_W-1:0]  col_pos = '0;
    t_square               best_so_far = '0;

    t_square expected_squares [$];
    int      mismatch_count = 0;
    int      burst_left = 0;
    bit      gaps_on = 1'b1;
    bit      hold_request = 1'b0;

    function automatic int eff_count(input logic [CFG_DATA_W-1:0] v, input int limit);
        if (v == 0)
            return 1;
        if (v > limit)
            return limit;
        return int'(v);
    endfunction

    // one cell of the running recurrence; pushes a square at the end of a grid
    function automatic void advance_grid(input logic [CHAR_W-1:0] ch);
        int r, c, up, lft, dg, side, cap;
        r = int'(row_pos);
        c = int'(col_pos);
        up = (r > 0) ? int'(line_sides[c]) : 0;
        lft = (c > 0) ? int'(left_side_p) : 0;
        dg = (r > 0 && c > 0) ? int'(diag_side_p) : 0;
        side = 0;
        if (ch != obstacle_cfg) begin
            side = 1 + ((lft < up) ? ((lft < dg) ? lft : dg) : ((up < dg) ? up : dg));
            cap = ((r < c) ? r : c) + 1;
            if (side > cap)
                side = cap;
        end
        diag_side_p = OUT_SIDE_W'(up);
        left_side_p = OUT_SIDE_W'(side);
        line_sides[c] = OUT_SIDE_W'(side);
        if (side > int'(best_so_far.side)) begin
            best_so_far.side = OUT_SIDE_W'(side);
            best_so_far.row = OUT_POS_W'(r + 1 - side);
            best_so_far.col = OUT_POS_W'(c + 1 - side);
        end
        if (c + 1 < eff_count(cols_cfg, MAX_COLS)) begin
            col_pos = OUT_POS_W'(c + 1);
            return;
        end
        col_pos = '0;
        left_side_p = '0;
        diag_side_p = '0;
        if (r + 1 < eff_count(rows_cfg, MAX_ROWS)) begin
            row_pos = OUT_POS_W'(r + 1);
            return;
        end
        expected_squares.push_back(best_so_far);
        row_pos = '0;
        best_so_far = '0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch: %s got %0d expected %0d", what, got, want);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_OBSTACLE: obstacle_cfg = val[CHAR_W-1:0];
            CFG_ROWS:     rows_cfg = val;
            CFG_COLS:     cols_cfg = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_cell(input logic [CHAR_W-1:0] ch);
        if (gaps_on && burst_left == 0) begin
            burst_left = int'($urandom_range(1, 24));
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cell_char <= ch;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        advance_grid(ch);
        if (burst_left > 0)
            burst_left--;
    endtask

    // drop valid, drain all results, then let the pipeline settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_squares.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        wait_idle();
        send_cell(OBSTACLE_RST);
        send_cell(8'd110);
        wait_idle();
        write_reg(CFG_UNUSED, 11'h7FF);
        send_cell(OBSTACLE_RST);
    endtask

    task automatic test_char_extremes();
        wait_idle();
        write_reg(CFG_OBSTACLE, 11'h000);
        send_cell(8'h00);
        send_cell(8'hFF);
        wait_idle();
        write_reg(CFG_OBSTACLE, 11'h7FF);
        send_cell(8'hFF);
    endtask

    task automatic test_tie_and_full();
        wait_idle();
        write_reg(CFG_OBSTACLE, {3'b000, CH_BLOCK});
        write_reg(CFG_ROWS, 11'd1);
        write_reg(CFG_COLS, 11'd3);
        // two equal squares: keep the first in raster order
        send_cell(CH_FREE);
        send_cell(CH_BLOCK);
        send_cell(CH_FREE);
        wait_idle();
        write_reg(CFG_ROWS, 11'd2);
        write_reg(CFG_COLS, 11'd2);
        repeat (4) send_cell(CH_FREE);
    endtask

    task automatic test_count_change_mid_grid();
        wait_idle();
        write_reg(CFG_ROWS, 11'd3);
        write_reg(CFG_COLS, 11'd3);
        repeat (4) send_cell(CH_FREE);
        wait_idle();
        // shrink the width: the next cell closes the row
        write_reg(CFG_COLS, 11'd2);
        send_cell(CH_FREE);
        send_cell(CH_BLOCK);
        wait_idle();
        // shrink the height below the current row: the grid ends at the wrap
        write_reg(CFG_ROWS, 11'd2);
        send_cell(CH_FREE);
    endtask

    task automatic test_count_extremes();
        int n, first_free;
        wait_idle();
        write_reg(CFG_OBSTACLE, {3'b101, CH_BLOCK});
        write_reg(CFG_ROWS, 11'd0);
        write_reg(CFG_COLS, 11'h7FF);
        first_free = int'($urandom_range(900, MAX_COLS - 1));
        for (n = 0; n < MAX_COLS; n++)
            send_cell((n >= first_free) ? CH_FREE : CH_BLOCK);
        wait_idle();
        write_reg(CFG_ROWS, 11'h7FF);
        write_reg(CFG_COLS, 11'd0);
        first_free = int'($urandom_range(900, MAX_ROWS - 1));
        for (n = 0; n < MAX_ROWS; n++)
            send_cell((n >= first_free) ? CH_FREE : CH_BLOCK);
    endtask

    task automatic test_backpressure();
        int n;
        wait_idle();
        write_reg(CFG_ROWS, 11'd1);
        write_reg(CFG_COLS, 11'd2);
        gaps_on = 1'b0;
        hold_request = 1'b1;
        for (n = 0; n < 60; n++)
            send_cell(CHAR_W'($urandom_range(0, 255)));
        gaps_on = 1'b1;
    endtask

    task automatic test_random_grids();
        int sent, n, cells, block_pct;
        logic [CFG_DATA_W-1:0] val;
        logic [CHAR_W-1:0] ch;
        sent = 0;
        while (sent < RANDOM_CELLS) begin
            wait_idle();
            val = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(7, 24))
                                              : CFG_DATA_W'($urandom_range(0, 6));
            write_reg(CFG_ROWS, val);
            val = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(13, 40))
                                              : CFG_DATA_W'($urandom_range(0, 12));
            write_reg(CFG_COLS, val);
            if ($urandom_range(0, 1)) begin
                val = CFG_DATA_W'($urandom_range(0, 2047));
                write_reg(CFG_OBSTACLE, val);
            end
            if ($urandom_range(0, 15) == 0) begin
                val = CFG_DATA_W'($urandom_range(0, 2047));
                write_reg(CFG_UNUSED, val);
            end
            block_pct = int'($urandom_range(0, 5)) * 10;
            gaps_on = ($urandom_range(0, 3) != 0);
            cells = eff_count(rows_cfg, MAX_ROWS) * eff_count(cols_cfg, MAX_COLS);
            // one to four grids back to back on one setting
            repeat ($urandom_range(1, 4)) begin
                for (n = 0; n < cells; n++) begin
                    if ($urandom_range(0, 99) < block_pct)
                        ch = obstacle_cfg;
                    else
                        ch = CHAR_W'($urandom_range(0, 255));
                    send_cell(ch);
                end
                sent += cells;
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_char_extremes();
        test_tie_and_full();
        test_count_change_mid_grid();
        test_count_extremes();
        test_backpressure();
        test_random_grids();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver: segments of steady, sparse, heavy and periodic stalls, plus a long hold
    initial begin : receiver
        logic stall_next;
        int seg_mode, seg_left, hold_left;
        seg_mode = 0;
        seg_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                stall_next = 1'b1;
                hold_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                stall_next = 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = int'($urandom_range(0, 3));
                    seg_left = int'($urandom_range(5, 60));
                end
                seg_left--;
                case (seg_mode)
                    0: stall_next = 1'b0;
                    1: stall_next = ($urandom_range(0, 3) == 0);
                    2: stall_next = ($urandom_range(0, 9) < 6);
                    default: stall_next = (seg_left % 3 == 0);
                endcase
            end
            i_stall <= stall_next;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_square want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_squares.size() == 0) begin
                report_mismatch("result with nothing expected, side", int'(o_best_side), -1);
            end else begin
                want = expected_squares.pop_front();
                if (o_best_row !== want.row)
                    report_mismatch("best_row", int'(o_best_row), int'(want.row));
                if (o_best_col !== want.col)
                    report_mismatch("best_col", int'(o_best_col), int'(want.col));
                if (o_best_side !== want.side)
                    report_mismatch("best_side", int'(o_best_side), int'(want.side));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
